### sv/aiir_pkg.sv
`timescale 1ns / 1ps

package aiir_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LR_W       = 32;
  localparam int unsigned WEIGHT_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LR,
    CFG_WEIGHT,
    CFG_FB1,
    CFG_FB2
  } cfg_reg_e;

  localparam logic [LR_W-1:0]     LR_RST     = 32'd2147484;  // ~0.0005 in Q0.32
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd13107;    // ~0.2 in Q0.16

  // Filter geometry: three feed-forward taps, gradient reaches two taps further back
  localparam int unsigned TAPS     = 3;
  localparam int unsigned RAW_TAPS = 2 * TAPS - 1;

  // Shared multiplier: 33x33 signed covers every operand pair of the datapath
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned ACC_W  = PROD_W + 2;

  // ceil(2^33 / 3): floor(p / 3) = (p * RECIP3) >> 33 for any 32-bit p
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  // Gradient magnitude is multiplied in two pieces split at this bit
  localparam int unsigned SPLIT = 24;
  // Upper partial product at or above 2^HS_W always saturates the step
  localparam int unsigned HS_W  = 38;
  // Lower partial product width: SPLIT bits times a 32-bit step
  localparam int unsigned LP_W  = SPLIT + 32;

  // MAC control, issued together with the operands
  typedef struct packed {
    logic en;   // accumulate this product
    logic clr;  // start a new sum with this product
    logic sub;  // subtract instead of add
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } aiir_state_e;

endpackage

### sv/adaptive_iir_filter_lms_feedforward.sv
// A new sample word is taken only once the last one is done; 22 products share one 33x33 multiplier
// (2 for the step size, 5 for the filter, 9 for the gradients, 6 for the updates).
// A waiting result word stalls only the final write of the result register.
// Reset (rst_ni low, asynchronous) zeroes the sample and output history and loads
// the default feed-forward and feedback coefficients, learning rate and weight.
`timescale 1ns / 1ps

module adaptive_iir_filter_lms_feedforward
  import aiir_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned COEF_FRAC_BITS = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_o,
  output logic                          clipped_o
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned CB    = COEF_FRAC_BITS + 4;
  localparam int unsigned GW    = 2 * SAMPLE_BITS + 3;
  localparam int unsigned MAG_W = (GW > 2 * SPLIT) ? GW : 2 * SPLIT;
  localparam int unsigned HI_W  = MAG_W - SPLIT;
  localparam int unsigned S_SH  = 32 - COEF_FRAC_BITS;
  localparam int unsigned DS_W  = HS_W + SPLIT - S_SH + 1;
  localparam int unsigned NC_W  = CB + 3;
  localparam int unsigned CNT_W = 5;

  // Coefficient reset values in Q3.F
  localparam longint ONE = longint'(1) << COEF_FRAC_BITS;
  localparam logic signed [CB-1:0] B0_RST  = CB'((2 * ONE + 5) / 10);
  localparam logic signed [CB-1:0] B1_RST  = CB'(-((3 * ONE + 5) / 10));
  localparam logic signed [CB-1:0] FB1_RST = CB'(-((14 * ONE + 5) / 10));
  localparam logic signed [CB-1:0] FB2_RST = CB'(ONE / 2);

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [DS_W-1:0]         CAP_V    = DS_W'(1) << (CB + 1);

  // Sequencer steps
  localparam logic [CNT_W-1:0] SQ_LRW  = 5'd0;   // lr * weight
  localparam logic [CNT_W-1:0] SQ_RCP  = 5'd1;   // divide by 3 via reciprocal
  localparam logic [CNT_W-1:0] SQ_B0   = 5'd2;   // filter taps
  localparam logic [CNT_W-1:0] SQ_B1   = 5'd3;
  localparam logic [CNT_W-1:0] SQ_B2   = 5'd4;
  localparam logic [CNT_W-1:0] SQ_A1   = 5'd5;
  localparam logic [CNT_W-1:0] SQ_A2   = 5'd6;
  localparam logic [CNT_W-1:0] SQ_G0A  = 5'd7;   // gradient terms, newest error last
  localparam logic [CNT_W-1:0] SQ_G0B  = 5'd8;
  localparam logic [CNT_W-1:0] SQ_G0C  = 5'd9;
  localparam logic [CNT_W-1:0] SQ_G1A  = 5'd10;
  localparam logic [CNT_W-1:0] SQ_G1B  = 5'd11;
  localparam logic [CNT_W-1:0] SQ_G1C  = 5'd12;
  localparam logic [CNT_W-1:0] SQ_G2A  = 5'd13;
  localparam logic [CNT_W-1:0] SQ_G2B  = 5'd14;
  localparam logic [CNT_W-1:0] SQ_G2C  = 5'd15;
  localparam logic [CNT_W-1:0] SQ_U0H  = 5'd16;  // update products, high then low piece
  localparam logic [CNT_W-1:0] SQ_U0L  = 5'd17;
  localparam logic [CNT_W-1:0] SQ_U1H  = 5'd18;
  localparam logic [CNT_W-1:0] SQ_U1L  = 5'd19;
  localparam logic [CNT_W-1:0] SQ_U2H  = 5'd20;
  localparam logic [CNT_W-1:0] SQ_U2L  = 5'd21;
  localparam logic [CNT_W-1:0] SQ_LAST = 5'd22;

  // Control state
  aiir_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free, out_load, in_acc, cfg_we, run, last;

  // Configuration registers
  logic [LR_W-1:0]          lr_q;
  logic [WEIGHT_W-1:0]      w_q;
  logic signed [CB-1:0]     fb1_q, fb2_q;

  // History and coefficients
  logic signed [SB-1:0]     x_q [RAW_TAPS];   // x[n] .. x[n-4]
  logic signed [SB-1:0]     f_q [TAPS-1];     // y[n-1], y[n-2]
  logic signed [CB-1:0]     coef_q [TAPS];

  // Working registers
  logic [31:0]              p_q, step_q, step_d;
  logic signed [SB-1:0]     y_q, y_d;
  logic                     clip_q, clip_d;
  logic [MAG_W-1:0]         mag_q [TAPS];
  logic                     neg_q [TAPS];
  logic [HS_W-1:0]          hs_q;
  logic                     hsat_q;
  logic signed [SB-1:0]     filtered_q;
  logic                     clipped_q;

  // Shared MAC
  mac_ctrl_t                mac_ctrl;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // Step decode
  logic                     g_en, g_clr, u_en, u_hi;
  logic [1:0]               g_k, g_i, u_k, cap_g_k, app_k;
  logic [2:0]               tap_idx;
  logic                     cap_p, cap_step, cap_y, cap_g, cap_hs, app_en;

  // Datapath helpers
  logic signed [SB:0]       err [TAPS];
  logic [31:0]              q3;
  logic [33:0]              three_q, rem3;
  logic signed [ACC_W-1:0]  acc_rnd, y_sh;
  logic signed [GW-1:0]     g_val;
  logic [GW-1:0]            g_mag;
  logic [DS_W-1:0]          dsum;
  logic [CB+1:0]            d_val;
  logic signed [NC_W-1:0]   nc, coef_ext, d_ext;
  logic signed [CB-1:0]     coef_new;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign run         = (state_q == ST_RUN);
  assign last        = run && (cnt_q == SQ_LAST);

  aiir_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  // Sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        if (cnt_q == SQ_LAST) begin
          cnt_d = '0;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // Errors y[n-i] - x[n-i]; y[n] is only valid from the step after it is rounded
  always_comb begin
    err[0] = (SB + 1)'(y_q) - (SB + 1)'(x_q[0]);
    err[1] = (SB + 1)'(f_q[0]) - (SB + 1)'(x_q[1]);
    err[2] = (SB + 1)'(f_q[1]) - (SB + 1)'(x_q[2]);
  end

  // Step decode: operands for the shared MAC and capture strobes
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mac_ctrl = '0;
    g_en     = 1'b0;
    g_clr    = 1'b0;
    g_k      = '0;
    g_i      = '0;
    u_en     = 1'b0;
    u_hi     = 1'b0;
    u_k      = '0;
    cap_p    = 1'b0;
    cap_step = 1'b0;
    cap_y    = 1'b0;
    cap_g    = 1'b0;
    cap_g_k  = '0;
    cap_hs   = 1'b0;
    app_en   = 1'b0;
    app_k    = '0;
    tap_idx  = '0;
    if (run) begin
      unique case (cnt_q)
        SQ_LRW: begin
          mul_a = MUL_W'({1'b0, lr_q});
          mul_b = MUL_W'({1'b0, w_q});
        end
        SQ_RCP: begin
          mul_a = MUL_W'({1'b0, prod[47:16]});
          mul_b = MUL_W'({1'b0, RECIP3});
          cap_p = 1'b1;
        end
        SQ_B0: begin
          mul_a    = MUL_W'(x_q[0]);
          mul_b    = MUL_W'(coef_q[0]);
          mac_ctrl = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
          cap_step = 1'b1;
        end
        SQ_B1: begin
          mul_a    = MUL_W'(x_q[1]);
          mul_b    = MUL_W'(coef_q[1]);
          mac_ctrl = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
        end
        SQ_B2: begin
          mul_a    = MUL_W'(x_q[2]);
          mul_b    = MUL_W'(coef_q[2]);
          mac_ctrl = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
        end
        SQ_A1: begin
          mul_a    = MUL_W'(f_q[0]);
          mul_b    = MUL_W'(fb1_q);
          mac_ctrl = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        end
        SQ_A2: begin
          mul_a    = MUL_W'(f_q[1]);
          mul_b    = MUL_W'(fb2_q);
          mac_ctrl = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        end
        SQ_G0A: begin
          g_en = 1'b1; g_clr = 1'b1; g_k = 2'd0; g_i = 2'd1;
        end
        SQ_G0B: begin
          g_en = 1'b1; g_k = 2'd0; g_i = 2'd2;
          cap_y = 1'b1;
        end
        SQ_G0C: begin
          g_en = 1'b1; g_k = 2'd0; g_i = 2'd0;
        end
        SQ_G1A: begin
          g_en = 1'b1; g_clr = 1'b1; g_k = 2'd1; g_i = 2'd1;
        end
        SQ_G1B: begin
          g_en = 1'b1; g_k = 2'd1; g_i = 2'd2;
          cap_g = 1'b1; cap_g_k = 2'd0;
        end
        SQ_G1C: begin
          g_en = 1'b1; g_k = 2'd1; g_i = 2'd0;
        end
        SQ_G2A: begin
          g_en = 1'b1; g_clr = 1'b1; g_k = 2'd2; g_i = 2'd1;
        end
        SQ_G2B: begin
          g_en = 1'b1; g_k = 2'd2; g_i = 2'd2;
          cap_g = 1'b1; cap_g_k = 2'd1;
        end
        SQ_G2C: begin
          g_en = 1'b1; g_k = 2'd2; g_i = 2'd0;
        end
        SQ_U0H: begin
          u_en = 1'b1; u_hi = 1'b1; u_k = 2'd0;
        end
        SQ_U0L: begin
          u_en = 1'b1; u_k = 2'd0;
          cap_g = 1'b1; cap_g_k = 2'd2;
          cap_hs = 1'b1;
        end
        SQ_U1H: begin
          u_en = 1'b1; u_hi = 1'b1; u_k = 2'd1;
          app_en = 1'b1; app_k = 2'd0;
        end
        SQ_U1L: begin
          u_en = 1'b1; u_k = 2'd1;
          cap_hs = 1'b1;
        end
        SQ_U2H: begin
          u_en = 1'b1; u_hi = 1'b1; u_k = 2'd2;
          app_en = 1'b1; app_k = 2'd1;
        end
        SQ_U2L: begin
          u_en = 1'b1; u_k = 2'd2;
          cap_hs = 1'b1;
        end
        SQ_LAST: begin
          app_en = 1'b1; app_k = 2'd2;
        end
        default: begin
        end
      endcase

      // gradient term e_i * x[n-i-k]
      if (g_en) begin
        tap_idx  = {1'b0, g_i} + {1'b0, g_k};
        mul_a    = MUL_W'(err[g_i]);
        mul_b    = MUL_W'(x_q[tap_idx]);
        mac_ctrl = '{en: 1'b1, clr: g_clr, sub: 1'b0};
      end

      // update piece |G_k| * step, product read straight from the multiplier
      if (u_en) begin
        mul_a = u_hi ? MUL_W'({1'b0, mag_q[u_k][MAG_W-1:SPLIT]})
                     : MUL_W'({1'b0, mag_q[u_k][SPLIT-1:0]});
        mul_b = MUL_W'({1'b0, step_q});
      end
    end
  end

  // Step size: 2p/3 = 2q + (remainder == 2), q = floor(p/3) from the reciprocal product
  always_comb begin
    q3      = prod[64:33];
    three_q = {1'b0, q3, 1'b0} + {2'b00, q3};
    rem3    = {2'b00, p_q} - three_q;
    step_d  = {q3[30:0], (rem3 == 34'd2)};
  end

  // Round half up, then saturate to the sample range
  always_comb begin
    acc_rnd = acc + RND_HALF;
    y_sh    = acc_rnd >>> COEF_FRAC_BITS;
    clip_d  = (y_sh[ACC_W-1:SB-1] != {(ACC_W - SB + 1){y_sh[SB-1]}});
    y_d     = clip_d ? {y_sh[ACC_W-1], {(SB - 1){~y_sh[ACC_W-1]}}} : y_sh[SB-1:0];
  end

  // Gradient sign and magnitude
  always_comb begin
    g_val = acc[GW-1:0];
    g_mag = g_val[GW-1] ? (~g_val + 1'b1) : g_val;
  end

  // Coefficient step: d = min(floor(|G| * step / 2^S_SH), cap), then saturate
  always_comb begin
    dsum     = (DS_W'(hs_q) << (SPLIT - S_SH)) + DS_W'(prod[LP_W-1:0] >> S_SH);
    d_val    = (hsat_q || (dsum > CAP_V)) ? (CB + 2)'(CAP_V) : dsum[CB+1:0];
    coef_ext = NC_W'(coef_q[app_k]);
    d_ext    = signed'({1'b0, d_val});
    nc       = neg_q[app_k] ? (coef_ext + d_ext) : (coef_ext - d_ext);
    coef_new = (nc[NC_W-1:CB-1] != {(NC_W - CB + 1){nc[CB-1]}})
               ? {nc[NC_W-1], {(CB - 1){~nc[NC_W-1]}}} : nc[CB-1:0];
  end

  // Control, configuration, history and coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      lr_q        <= LR_RST;
      w_q         <= WEIGHT_RST;
      fb1_q       <= FB1_RST;
      fb2_q       <= FB2_RST;
      for (int i = 0; i < RAW_TAPS; i++) begin
        x_q[i] <= '0;
      end
      for (int i = 0; i < TAPS - 1; i++) begin
        f_q[i] <= '0;
      end
      coef_q[0] <= B0_RST;
      coef_q[1] <= B1_RST;
      coef_q[2] <= B0_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;

      if (cfg_we) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_LR:     lr_q  <= cfg_data_i[LR_W-1:0];
          CFG_WEIGHT: w_q   <= cfg_data_i[WEIGHT_W-1:0];
          CFG_FB1:    fb1_q <= cfg_data_i[CB-1:0];
          CFG_FB2:    fb2_q <= cfg_data_i[CB-1:0];
          default: begin
          end
        endcase
      end

      // new sample word enters the raw history
      if (in_acc) begin
        x_q[0] <= sample_i;
        for (int i = 1; i < RAW_TAPS; i++) begin
          x_q[i] <= x_q[i-1];
        end
      end

      // output history advances once the word is done
      if (last) begin
        f_q[0] <= y_q;
        for (int i = 1; i < TAPS - 1; i++) begin
          f_q[i] <= f_q[i-1];
        end
      end

      if (app_en) begin
        coef_q[app_k] <= coef_new;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cap_p) begin
      p_q <= prod[47:16];
    end
    if (cap_step) begin
      step_q <= step_d;
    end
    if (cap_y) begin
      y_q    <= y_d;
      clip_q <= clip_d;
    end
    if (cap_g) begin
      mag_q[cap_g_k] <= MAG_W'(g_mag);
      neg_q[cap_g_k] <= g_val[GW-1];
    end
    if (cap_hs) begin
      hs_q   <= prod[HS_W-1:0];
      hsat_q <= |prod[PROD_W-1:HS_W];
    end
    if (out_load) begin
      filtered_q <= y_q;
      clipped_q  <= clip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign clipped_o   = clipped_q;

  // A result word appears only as a word finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past((state_q == ST_RUN && cnt_q == SQ_LAST) ||
                                 state_q == ST_HOLD))
    else $error("result word loaded outside the final step");

  // An accepted sample word starts the sequence at its first step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_RUN && cnt_q == SQ_LRW))
    else $error("sequencer did not start on an accepted word");

  // Step counter rests at zero outside a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> (cnt_q == '0))
    else $error("step counter moved outside a run");

  // Holding only happens behind a pending result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> out_valid_q)
    else $error("hold state without a pending result word");

endmodule

### sv/aiir_mac.sv
`timescale 1ns / 1ps

module aiir_mac
  import aiir_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctrl_t                ctrl_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, acc_base, prod_ext;
  mac_ctrl_t                ctrl_q;

  // Product register: one multiply per cycle
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  // Control is registered alongside its product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  // Accumulate stage
  always_comb begin
    acc_base = ctrl_q.clr ? '0 : acc_q;
    prod_ext = ACC_W'(prod_q);
    acc_d    = ctrl_q.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_q.en) begin
      acc_q <= acc_d;
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import aiir_pkg::*;

  localparam int unsigned SW         = 16;
  localparam int unsigned CFB        = 20;
  localparam int unsigned CW         = CFB + 4;
  localparam int unsigned HIST_DEPTH = 6;
  localparam int unsigned LATENCY    = 23;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned WDOG_LIMIT = 4000;
  localparam int unsigned N_PHASES   = 8;
  localparam int unsigned PHASE_LEN  = 180;
  localparam int unsigned MAX_PRINTS = 200;

  localparam longint SMAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam longint unsigned STEP_CAP = longint'(1) << (CW + 1);

  // one result word as the filter should produce it
  typedef struct packed {
    logic signed [SW-1:0] filtered;
    logic                 clipped;
  } filt_word_t;

  // directed row: either a register write or a sample word
  typedef struct packed {
    logic                 is_cfg;
    cfg_reg_e             reg_sel;
    logic [31:0]          reg_data;
    logic signed [SW-1:0] sample;
    logic                 typed;
    logic signed [SW-1:0] exp_filtered;
    logic                 exp_clipped;
  } dir_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic signed [SW-1:0] sample_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [SW-1:0] filtered_o;
  logic                 clipped_o;

  // filter model state
  longint          raw_hist  [HIST_DEPTH];
  longint          filt_hist [HIST_DEPTH];
  int unsigned     wr_ptr;
  longint          ff_taps   [TAPS];
  longint unsigned lr_q;
  longint unsigned wt_q;
  longint          a1_q;
  longint          a2_q;

  filt_word_t pending_outputs[$];
  int         mismatch_count = 0;
  int         stall_cycles   = 0;
  int         tx_idle_pct    = 0;
  int         rx_stall_pct   = 0;
  bit         hold_req       = 1'b0;

  dir_row_t dir_rows [0:23] = '{
    // reset settings: a zero word, then full scale on an empty history
    '{1'b0, CFG_LR, 32'd0, 16'sh0000, 1'b1, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh7FFF, 1'b1, 16'sd6553, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh8000, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh8000, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh7FFF, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh0001, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'shFFFF, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh5555, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'shAAAA, 1'b0, 16'sh0000, 1'b0},
    // largest step, extreme feedback, junk above the register widths
    '{1'b1, CFG_LR,     32'hFFFF_FFFF, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
    '{1'b1, CFG_WEIGHT, 32'hA5A5_FFFF, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
    '{1'b1, CFG_FB1,    32'hA580_0000, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
    '{1'b1, CFG_FB2,    32'h5A7F_FFFF, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
    // full-scale runs: huge gradients, clipping, ring wrap
    '{1'b0, CFG_LR, 32'd0, 16'sh7FFF, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh7FFF, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh7FFF, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh8000, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh8000, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh7FFF, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh0000, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh8000, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'sh3039, 1'b0, 16'sh0000, 1'b0},
    '{1'b0, CFG_LR, 32'd0, 16'shFFFF, 1'b0, 16'sh0000, 1'b0}
  };

  adaptive_iir_filter_lms_feedforward #(
    .SAMPLE_BITS   (SW),
    .COEF_FRAC_BITS(CFB)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .filtered_o (filtered_o),
    .clipped_o  (clipped_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned past(int unsigned d);
    return (wr_ptr + HIST_DEPTH - d) % HIST_DEPTH;
  endfunction

  // filter one sample, then move b0..b2 one gradient step
  function automatic void predict_filtered(input logic signed [SW-1:0] x,
                                           output logic signed [SW-1:0] y_o,
                                           output logic clip_o);
    longint          acc;
    longint          y;
    longint          grad;
    longint          tap;
    longint unsigned mag;
    longint unsigned step;
    longint unsigned delta;
    logic [127:0]    prod;
    wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    raw_hist[wr_ptr] = x;

    acc = 0;
    for (int k = 0; k < TAPS; k++) acc += raw_hist[past(k)] * ff_taps[k];
    acc -= filt_hist[past(1)] * a1_q;
    acc -= filt_hist[past(2)] * a2_q;
    acc += longint'(1) << (CFB - 1);
    y = acc >>> CFB;
    clip_o = 1'b0;
    if (y > SMAX) begin
      y = SMAX;
      clip_o = 1'b1;
    end else if (y < SMIN) begin
      y = SMIN;
      clip_o = 1'b1;
    end
    filt_hist[wr_ptr] = y;
    y_o = y[SW-1:0];

    // step = lr * w * 2/3, Q0.32
    step = ((lr_q * wt_q) >> 16) * 2 / 3;
    for (int k = 0; k < TAPS; k++) begin
      grad = 0;
      for (int i = 0; i < TAPS; i++)
        grad += (filt_hist[past(i)] - raw_hist[past(i)]) * raw_hist[past(i + k)];
      mag = (grad < 0) ? -grad : grad;
      prod = (128'(mag) * 128'(step)) >> (32 - CFB);
      delta = (prod > 128'(STEP_CAP)) ? STEP_CAP : prod[63:0];
      tap = (grad < 0) ? ff_taps[k] + signed'(delta) : ff_taps[k] - signed'(delta);
      if (tap > CMAX) tap = CMAX;
      else if (tap < CMIN) tap = CMIN;
      ff_taps[k] = tap;
    end
  endfunction

  // stop offering words until every result is back and the block has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [31:0] d);
    logic signed [CW-1:0] fb;
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    fb = d[CW-1:0];
    case (sel)
      CFG_LR:     lr_q = d;
      CFG_WEIGHT: wt_q = d[WEIGHT_W-1:0];
      CFG_FB1:    a1_q = fb;
      CFG_FB2:    a2_q = fb;
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic signed [SW-1:0] x, input logic typed,
                             input logic signed [SW-1:0] ty, input logic tclip);
    filt_word_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_filtered(x, pred.filtered, pred.clipped);
    if (typed) begin
      pred.filtered = ty;
      pred.clipped  = tclip;
    end
    pending_outputs.push_back(pred);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin : result_sink
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_outputs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_PRINTS)
            $display("%0t: unexpected word, filtered %0d clipped %0b", $time,
                     filtered_o, clipped_o);
        end else begin
          filt_word_t want;
          want = pending_outputs.pop_front();
          if (filtered_o !== want.filtered) begin
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTS)
              $display("%0t: filtered expected %0d actual %0d", $time,
                       want.filtered, filtered_o);
          end
          if (clipped_o !== want.clipped) begin
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTS)
              $display("%0t: clipped expected %0b actual %0b", $time,
                       want.clipped, clipped_o);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic signed [SW-1:0] x;
    logic [31:0]          lr_v;
    logic [15:0]          wt_v;
    logic [CW-1:0]        fb1_v;
    logic [CW-1:0]        fb2_v;
    int                   walk;

    // model state after reset
    foreach (raw_hist[i]) begin
      raw_hist[i]  = 0;
      filt_hist[i] = 0;
    end
    wr_ptr     = 0;
    ff_taps[0] = 209715;
    ff_taps[1] = -314573;
    ff_taps[2] = 209715;
    lr_q       = LR_RST;
    wt_q       = WEIGHT_RST;
    a1_q       = -1468006;
    a2_q       = 524288;
    walk       = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg)
        write_reg(dir_rows[r].reg_sel, dir_rows[r].reg_data);
      else
        send_sample(dir_rows[r].sample, dir_rows[r].typed,
                    dir_rows[r].exp_filtered, dir_rows[r].exp_clipped);
    end

    // random phases, each with its own settings and one of four idling mixes
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          lr_v = '0; wt_v = '0; fb1_v = '0; fb2_v = '0;
        end
        1: begin
          lr_v = '1; wt_v = '1; fb1_v = 24'h7F_FFFF; fb2_v = 24'h80_0000;
        end
        2: begin
          lr_v = LR_RST; wt_v = WEIGHT_RST;
          fb1_v = CW'(-1468006); fb2_v = CW'(524288);
        end
        default: begin
          lr_v  = $urandom() >> $urandom_range(31, 0);
          wt_v  = 16'($urandom()) >> $urandom_range(15, 0);
          fb1_v = CW'(int'($urandom_range(3984588)) - 1992294);
          fb2_v = CW'(int'($urandom_range(1887436)) - 943718);
          if ($urandom_range(3) == 0) fb1_v = CW'($urandom());
          if ($urandom_range(3) == 0) fb2_v = CW'($urandom());
        end
      endcase
      write_reg(CFG_LR, lr_v);
      write_reg(CFG_WEIGHT, {16'($urandom()), wt_v});
      write_reg(CFG_FB1, {8'($urandom()), fb1_v});
      write_reg(CFG_FB2, {8'($urandom()), fb2_v});

      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase

      for (int n = 0; n < PHASE_LEN; n++) begin
        // back-pressure test: sink holds off while words keep coming
        if (p == 0 && n == 40) hold_req = 1'b1;
        case ($urandom_range(3))
          0, 1: x = SW'($urandom());
          2: begin
            walk = walk + int'($urandom_range(4000)) - 2000;
            if (walk > 32767) walk = 32767;
            if (walk < -32768) walk = -32768;
            x = SW'(walk);
          end
          default: begin
            case ($urandom_range(4))
              0: x = 16'sh7FFF;
              1: x = 16'sh8000;
              2: x = SW'(int'($urandom_range(1023)) - 512);
              3: x = 16'sh0001;
              default: x = 16'shFFFF;
            endcase
          end
        endcase
        send_sample(x, 1'b0, '0, 1'b0);
      end
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    wait_idle();
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
